// File: design/msp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Shared widths, limits, codes and types of the motor speed PID controller.
// ----------------------------------------------------------------------------
package msp_pkg;

    // field widths
    localparam int REF_W     = 24;
    localparam int COUNT_W   = 32;
    localparam int ELAPSED_W = 16;
    localparam int GAIN_W    = 24;
    localparam int SPEED_W   = 24;
    localparam int DRIVE_W   = 17;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int ERR_W     = 25;
    localparam int SUM_W     = 12;
    localparam int SUM_RAW_W = 26;
    localparam int DIFF_W    = 26;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 26;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 52;
    localparam int DIVD_W    = 42;
    localparam int QUO_W     = 24;
    localparam int CNT_W     = 5;
    localparam int CLAMP_W   = 25;
    localparam int FRAC_SH   = 8;

    // constants
    localparam int MS_PER_S      = 1000;
    localparam int SUM_LIMIT     = 2000;
    localparam int OUT_LIMIT_Q16 = 255 * 65536;
    localparam int ONE_Q16       = 65536;
    localparam int ROUND_ADD     = (1 << FRAC_SH) - 1;

    localparam logic signed [SPEED_W-1:0]   SPEED_MAX  = SPEED_W'(8388607);
    localparam logic signed [SPEED_W-1:0]   SPEED_MIN  = SPEED_W'(-8388608);
    localparam logic [QUO_W-1:0]            QUO_POS_MAX = QUO_W'(8388607);
    localparam logic [QUO_W-1:0]            QUO_NEG_MAX = QUO_W'(8388608);
    localparam logic signed [SUM_RAW_W-1:0] SUM_HI     = SUM_RAW_W'(SUM_LIMIT);
    localparam logic signed [SUM_RAW_W-1:0] SUM_LO     = SUM_RAW_W'(-SUM_LIMIT);
    localparam logic signed [ACC_W-1:0]     ACC_HI     = ACC_W'(OUT_LIMIT_Q16);
    localparam logic signed [ACC_W-1:0]     ACC_LO     = ACC_W'(-OUT_LIMIT_Q16);
    localparam logic signed [CLAMP_W-1:0]   CLAMP_ONE  = CLAMP_W'(ONE_Q16);
    localparam logic signed [CLAMP_W-1:0]   CLAMP_MONE = CLAMP_W'(-ONE_Q16);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2
    } cfg_index_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPD_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_OUT
    } state_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage
`default_nettype wire

// File: design/motor_speed_pid_controller.sv
// The result waits on the speed divider, which takes 24 one-bit steps; with
// elapsed_ms of 0 the divider is skipped and the speed is taken as 0.
// A new request is taken only in idle, once the last one is handed over; the
// shared multiplier takes four products, the divider runs between them.
// A finished result waits in the output register while the next request runs.
// Reset (rst_n low, asynchronous) clears gains, last count, error and sum.
`default_nettype none
// ----------------------------------------------------------------------------
// motor_speed_pid_controller
// Speed from encoder count delta, PID law with clamped integral, output
// clamp and forward/reverse duty split, on a shared multiplier and divider.
// ----------------------------------------------------------------------------
module motor_speed_pid_controller (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic        [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [msp_pkg::GAIN_W-1:0]     cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [msp_pkg::REF_W-1:0]      reference,
    input  wire logic signed [msp_pkg::COUNT_W-1:0]    encoder_count,
    input  wire logic        [msp_pkg::ELAPSED_W-1:0]  elapsed_ms,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed      [msp_pkg::SPEED_W-1:0]    speed,
    output logic signed      [msp_pkg::DRIVE_W-1:0]    drive_value,
    output logic             [msp_pkg::DUTY_W-1:0]     forward_duty,
    output logic             [msp_pkg::DUTY_W-1:0]     reverse_duty
);

    localparam int CW = msp_pkg::CLAMP_W;

    msp_pkg::state_t state_reg;
    msp_pkg::state_t state_next;

    logic [msp_pkg::GAIN_W-1:0] prop_gain_reg;
    logic [msp_pkg::GAIN_W-1:0] prop_gain_next;
    logic [msp_pkg::GAIN_W-1:0] integ_gain_reg;
    logic [msp_pkg::GAIN_W-1:0] integ_gain_next;
    logic [msp_pkg::GAIN_W-1:0] deriv_gain_reg;
    logic [msp_pkg::GAIN_W-1:0] deriv_gain_next;

    logic [msp_pkg::COUNT_W-1:0]       last_count_reg;
    logic [msp_pkg::COUNT_W-1:0]       last_count_next;
    logic signed [msp_pkg::ERR_W-1:0]  last_error_reg;
    logic signed [msp_pkg::ERR_W-1:0]  last_error_next;
    logic signed [msp_pkg::SUM_W-1:0]  error_sum_reg;
    logic signed [msp_pkg::SUM_W-1:0]  error_sum_next;

    logic signed [msp_pkg::REF_W-1:0]   ref_reg;
    logic signed [msp_pkg::REF_W-1:0]   ref_next;
    logic [msp_pkg::ELAPSED_W-1:0]      elapsed_reg;
    logic [msp_pkg::ELAPSED_W-1:0]      elapsed_next;
    logic signed [msp_pkg::COUNT_W-1:0] delta_reg;
    logic signed [msp_pkg::COUNT_W-1:0] delta_next;
    logic signed [msp_pkg::SPEED_W-1:0] speed_reg;
    logic signed [msp_pkg::SPEED_W-1:0] speed_next;
    logic signed [msp_pkg::DIFF_W-1:0]  diff_reg;
    logic signed [msp_pkg::DIFF_W-1:0]  diff_next;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [msp_pkg::SPEED_W-1:0] out_speed_reg;
    logic signed [msp_pkg::SPEED_W-1:0] out_speed_next;
    logic signed [msp_pkg::DRIVE_W-1:0] out_drive_reg;
    logic signed [msp_pkg::DRIVE_W-1:0] out_drive_next;
    logic [msp_pkg::DUTY_W-1:0]         out_fwd_reg;
    logic [msp_pkg::DUTY_W-1:0]         out_fwd_next;
    logic [msp_pkg::DUTY_W-1:0]         out_rev_reg;
    logic [msp_pkg::DUTY_W-1:0]         out_rev_next;

    msp_pkg::mac_ctrl_t                  mac_ctrl;
    logic signed [msp_pkg::MUL_A_W-1:0]  mac_a;
    logic signed [msp_pkg::MUL_B_W-1:0]  mac_b;
    logic signed [msp_pkg::PROD_W-1:0]   mac_prod;
    logic signed [msp_pkg::ACC_W-1:0]    mac_acc;

    logic                                div_start;
    logic                                div_done;
    logic signed [msp_pkg::SPEED_W-1:0]  div_quo;

    logic signed [msp_pkg::ERR_W-1:0]     err_calc;
    logic signed [msp_pkg::SUM_RAW_W-1:0] sum_raw;
    logic signed [msp_pkg::SUM_W-1:0]     sum_clamp;
    logic signed [msp_pkg::ACC_W-1:0]     acc_clamp;
    logic signed [CW-1:0]                 out_q16;
    logic signed [CW-1:0]                 out_adj;
    logic signed [msp_pkg::DRIVE_W-1:0]   drive_calc;
    logic signed [msp_pkg::DRIVE_W-1:0]   drive_neg;
    logic                                 in_take;
    logic                                 out_free;

    // shared multiply-accumulate unit
    msp_mul_acc u_mul_acc (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    // speed divider
    msp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mac_prod[msp_pkg::DIVD_W-1:0]),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == msp_pkg::ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // error and clamped error sum
    always_comb
    begin
        if (ref_reg == '0)
        begin
            err_calc = '0;
        end
        else
        begin
            err_calc = msp_pkg::ERR_W'(ref_reg) - msp_pkg::ERR_W'(speed_reg);
        end
        sum_raw = msp_pkg::SUM_RAW_W'(error_sum_reg) + msp_pkg::SUM_RAW_W'(err_calc);
        if (ref_reg == '0)
        begin
            sum_clamp = '0;
        end
        else if (sum_raw > msp_pkg::SUM_HI)
        begin
            sum_clamp = msp_pkg::SUM_W'(msp_pkg::SUM_HI);
        end
        else if (sum_raw < msp_pkg::SUM_LO)
        begin
            sum_clamp = msp_pkg::SUM_W'(msp_pkg::SUM_LO);
        end
        else
        begin
            sum_clamp = msp_pkg::SUM_W'(sum_raw);
        end
    end

    // output clamp, truncation toward zero and negated drive
    always_comb
    begin
        if (mac_acc > msp_pkg::ACC_HI)
        begin
            acc_clamp = msp_pkg::ACC_HI;
        end
        else if (mac_acc < msp_pkg::ACC_LO)
        begin
            acc_clamp = msp_pkg::ACC_LO;
        end
        else
        begin
            acc_clamp = mac_acc;
        end
        out_q16    = $signed(acc_clamp[CW-1:0]);
        out_adj    = out_q16 + (out_q16[CW-1] ? CW'(msp_pkg::ROUND_ADD) : CW'(0));
        drive_calc = $signed(out_adj[CW-1:msp_pkg::FRAC_SH]);
        drive_neg  = -drive_calc;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        prop_gain_next  = prop_gain_reg;
        integ_gain_next = integ_gain_reg;
        deriv_gain_next = deriv_gain_reg;
        last_count_next = last_count_reg;
        last_error_next = last_error_reg;
        error_sum_next  = error_sum_reg;
        ref_next        = ref_reg;
        elapsed_next    = elapsed_reg;
        delta_next      = delta_reg;
        speed_next      = speed_reg;
        diff_next       = diff_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_speed_next  = out_speed_reg;
        out_drive_next  = out_drive_reg;
        out_fwd_next    = out_fwd_reg;
        out_rev_next    = out_rev_reg;
        mac_ctrl        = '0;
        mac_a           = msp_pkg::MUL_A_W'(delta_reg);
        mac_b           = msp_pkg::MUL_B_W'(msp_pkg::MS_PER_S);
        div_start       = 1'b0;

        // gain writes
        if (cfg_valid)
        begin
            case (cfg_index)
                msp_pkg::CFG_PROP_GAIN:  prop_gain_next  = cfg_data;
                msp_pkg::CFG_INTEG_GAIN: integ_gain_next = cfg_data;
                msp_pkg::CFG_DERIV_GAIN: deriv_gain_next = cfg_data;
                default:                 ;
            endcase
        end

        case (state_reg)
            msp_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    ref_next        = reference;
                    elapsed_next    = elapsed_ms;
                    delta_next      = $signed(encoder_count - last_count_reg);
                    last_count_next = encoder_count;
                    state_next      = msp_pkg::ST_SPD_MUL;
                end
            end
            msp_pkg::ST_SPD_MUL:
            begin
                // count delta times 1000
                mac_ctrl.mul_en = 1'b1;
                state_next      = msp_pkg::ST_DIV_START;
            end
            msp_pkg::ST_DIV_START:
            begin
                if (elapsed_reg == '0)
                begin
                    speed_next = '0;
                    state_next = msp_pkg::ST_ERR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = msp_pkg::ST_DIV_WAIT;
                end
            end
            msp_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    speed_next = div_quo;
                    state_next = msp_pkg::ST_ERR;
                end
            end
            msp_pkg::ST_ERR:
            begin
                last_error_next = err_calc;
                error_sum_next  = sum_clamp;
                diff_next       = msp_pkg::DIFF_W'(err_calc) - msp_pkg::DIFF_W'(last_error_reg);
                mac_ctrl.clear  = 1'b1;
                state_next      = msp_pkg::ST_MUL_P;
            end
            msp_pkg::ST_MUL_P:
            begin
                mac_a           = $signed(msp_pkg::MUL_A_W'(prop_gain_reg));
                mac_b           = msp_pkg::MUL_B_W'(last_error_reg);
                mac_ctrl.mul_en = 1'b1;
                state_next      = msp_pkg::ST_MUL_I;
            end
            msp_pkg::ST_MUL_I:
            begin
                mac_a           = $signed(msp_pkg::MUL_A_W'(integ_gain_reg));
                mac_b           = msp_pkg::MUL_B_W'(error_sum_reg);
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                state_next      = msp_pkg::ST_MUL_D;
            end
            msp_pkg::ST_MUL_D:
            begin
                mac_a           = $signed(msp_pkg::MUL_A_W'(deriv_gain_reg));
                mac_b           = diff_reg;
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_en = 1'b1;
                state_next      = msp_pkg::ST_ACC;
            end
            msp_pkg::ST_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next      = msp_pkg::ST_OUT;
            end
            msp_pkg::ST_OUT:
            begin
                // hand the result over once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_speed_next = speed_reg;
                    out_drive_next = drive_calc;
                    out_fwd_next   = '0;
                    out_rev_next   = '0;
                    if (out_q16 > msp_pkg::CLAMP_ONE)
                    begin
                        out_fwd_next = drive_calc[msp_pkg::FRAC_SH +: msp_pkg::DUTY_W];
                    end
                    else if (out_q16 < msp_pkg::CLAMP_MONE)
                    begin
                        out_rev_next = drive_neg[msp_pkg::FRAC_SH +: msp_pkg::DUTY_W];
                    end
                    state_next = msp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msp_pkg::ST_IDLE;
            end
        endcase
    end

    // control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= msp_pkg::ST_IDLE;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            last_count_reg <= '0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prop_gain_reg  <= prop_gain_next;
            integ_gain_reg <= integ_gain_next;
            deriv_gain_reg <= deriv_gain_next;
            last_count_reg <= last_count_next;
            last_error_reg <= last_error_next;
            error_sum_reg  <= error_sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        ref_reg       <= ref_next;
        elapsed_reg   <= elapsed_next;
        delta_reg     <= delta_next;
        speed_reg     <= speed_next;
        diff_reg      <= diff_next;
        out_speed_reg <= out_speed_next;
        out_drive_reg <= out_drive_next;
        out_fwd_reg   <= out_fwd_next;
        out_rev_reg   <= out_rev_next;
    end

    assign out_valid    = out_valid_reg;
    assign speed        = out_speed_reg;
    assign drive_value  = out_drive_reg;
    assign forward_duty = out_fwd_reg;
    assign reverse_duty = out_rev_reg;

endmodule
`default_nettype wire

// File: design/msp_mul_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_mul_acc
// Shared signed multiplier with a product register and an accumulator.
// ----------------------------------------------------------------------------
module msp_mul_acc (
    input  wire logic                                clk,
    input  wire msp_pkg::mac_ctrl_t                  ctrl,
    input  wire logic signed [msp_pkg::MUL_A_W-1:0]  op_a,
    input  wire logic signed [msp_pkg::MUL_B_W-1:0]  op_b,
    output logic signed      [msp_pkg::PROD_W-1:0]   prod,
    output logic signed      [msp_pkg::ACC_W-1:0]    acc
);

    logic signed [msp_pkg::PROD_W-1:0] prod_reg;
    logic signed [msp_pkg::PROD_W-1:0] prod_next;
    logic signed [msp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [msp_pkg::ACC_W-1:0]  acc_next;

    // one multiply per cycle while mul_en is set, then accumulate the registered product when acc_en is set
    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctrl.mul_en)
        begin
            prod_next = op_a * op_b;
        end
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + $signed(prod_reg[msp_pkg::ACC_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule
`default_nettype wire

// File: design/msp_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_divider
// Restoring divider, one quotient bit a cycle, signed result saturated
// to the speed width.
// ----------------------------------------------------------------------------
module msp_divider (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic signed [msp_pkg::DIVD_W-1:0]    dividend,
    input  wire logic        [msp_pkg::ELAPSED_W-1:0] divisor,
    output logic                                      done,
    output logic signed      [msp_pkg::SPEED_W-1:0]   quotient
);

    localparam int DW = msp_pkg::ELAPSED_W;
    localparam int QW = msp_pkg::QUO_W;
    localparam int HI_W = msp_pkg::DIVD_W - QW;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [msp_pkg::CNT_W-1:0] cnt_reg;
    logic [msp_pkg::CNT_W-1:0] cnt_next;
    logic                neg_reg;
    logic                neg_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [DW-1:0]       rem_reg;
    logic [DW-1:0]       rem_next;
    logic [QW-1:0]       quo_reg;
    logic [QW-1:0]       quo_next;
    logic [DW-1:0]       dsr_reg;
    logic [DW-1:0]       dsr_next;

    logic [msp_pkg::DIVD_W-1:0] mag;
    logic [DW:0]                trial;
    logic [DW:0]                trial_sub;
    logic                       trial_ge;

    // magnitude of the dividend
    assign mag = dividend[msp_pkg::DIVD_W-1] ? msp_pkg::DIVD_W'(-dividend)
                                             : msp_pkg::DIVD_W'(dividend);

    // one restoring step
    assign trial     = {rem_reg, quo_reg[QW-1]};
    assign trial_ge  = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[msp_pkg::DIVD_W-1];
            // quotient of 2^24 or more saturates
            ovf_next  = mag[msp_pkg::DIVD_W-1:QW] >= HI_W'(divisor);
            rem_next  = mag[QW +: DW];
            quo_next  = mag[QW-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[QW-2:0], trial_ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == msp_pkg::CNT_W'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath flops
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // sign and saturation of the result
    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || quo_reg > msp_pkg::QUO_NEG_MAX)
            begin
                quotient = msp_pkg::SPEED_MIN;
            end
            else
            begin
                quotient = $signed(-quo_reg);
            end
        end
        else
        begin
            if (ovf_reg || quo_reg > msp_pkg::QUO_POS_MAX)
            begin
                quotient = msp_pkg::SPEED_MAX;
            end
            else
            begin
                quotient = $signed(quo_reg);
            end
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// File: design/msp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks of the motor speed PID controller, bound to the top.
// ----------------------------------------------------------------------------
module msp_checker (
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  cfg_valid,
    input wire logic                                  cfg_ready,
    input wire logic        [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic        [msp_pkg::GAIN_W-1:0]     cfg_data,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic signed [msp_pkg::REF_W-1:0]      reference,
    input wire logic signed [msp_pkg::COUNT_W-1:0]    encoder_count,
    input wire logic        [msp_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic signed [msp_pkg::SPEED_W-1:0]    speed,
    input wire logic signed [msp_pkg::DRIVE_W-1:0]    drive_value,
    input wire logic        [msp_pkg::DUTY_W-1:0]     forward_duty,
    input wire logic        [msp_pkg::DUTY_W-1:0]     reverse_duty
);

    // an accepted request keeps the block busy on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("msp: ready right after a request was taken");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(drive_value) && $stable(speed)))
        else $error("msp: stalled result changed");

    // only one direction drives at a time
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (forward_duty == '0 || reverse_duty == '0))
        else $error("msp: forward and reverse duty both set");

    // forward duty is the integer part of a positive drive
    a_fwd_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && forward_duty != '0) |->
        (!drive_value[msp_pkg::DRIVE_W-1] && drive_value[15:8] == forward_duty))
        else $error("msp: forward duty disagrees with drive value");

    // drive stays inside the output clamp
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_value <= 17'sd65280 && drive_value >= -17'sd65280))
        else $error("msp: drive value outside clamp");

endmodule

bind motor_speed_pid_controller msp_checker u_msp_checker (.*);
`default_nettype wire
